/* src/skt_pkg.sv */
`default_nettype none
package skt_pkg;

	localparam int BANK_DEPTH_DEF = 64;
	localparam int KEY_W = 32;
	localparam int PAY_W = 16;
	localparam int POS_W = 6;
	localparam int STEP_W = 5;

	localparam logic [1:0] OP_STORE_NORMAL = 2'd0;
	localparam logic [1:0] OP_STORE_ISO = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;
	localparam logic [1:0] OP_LOOKUP = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_DUP = 2'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic [KEY_W-1:0] key_id;
		logic [PAY_W-1:0] payload_in;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic hit_bank;
		logic [POS_W-1:0] position;
		logic [PAY_W-1:0] payload_out;
	} out_word_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_REQ,
		C_SEARCH_DONE,
		C_IS_FIND,
		C_FOUND,
		C_FULL,
		C_PTR_LE_LO,
		C_BANK_ISO,
		C_IS_LOOKUP,
		C_PTR_AT_TOP,
		C_OUT_BUSY
	} cond_sel_t;

	typedef struct packed {
		logic no_req;
		logic search_done;
		logic is_find;
		logic found;
		logic full;
		logic ptr_le_lo;
		logic bank_iso;
		logic is_lookup;
		logic ptr_at_top;
		logic out_busy;
	} cond_t;

	typedef struct packed {
		logic init;
		logic probe;
		logic cmp;
		logic up_set;
		logic up_rd;
		logic up_wr;
		logic ins_wr;
		logic next_bank;
		logic ptr_lo;
		logic dn_rd;
		logic dn_wr;
		logic dec;
		logic emit;
	} act_t;

	typedef struct packed {
		logic [1:0] status;
		logic pos_sel;
		logic pay_sel;
		logic bank_sel;
	} res_t;

	typedef struct packed {
		cond_sel_t cond;
		logic [STEP_W-1:0] target;
		logic done;
		act_t act;
		res_t res;
	} ctrl_t;

	localparam logic [STEP_W-1:0] S_IDLE = 5'd0;
	localparam logic [STEP_W-1:0] S_PROBE = 5'd1;
	localparam logic [STEP_W-1:0] S_CMP = 5'd2;
	localparam logic [STEP_W-1:0] S_DISPATCH = 5'd3;
	localparam logic [STEP_W-1:0] S_DUP_CHK = 5'd4;
	localparam logic [STEP_W-1:0] S_FULL_CHK = 5'd5;
	localparam logic [STEP_W-1:0] S_UP_SET = 5'd6;
	localparam logic [STEP_W-1:0] S_UP_RD = 5'd7;
	localparam logic [STEP_W-1:0] S_UP_WR = 5'd8;
	localparam logic [STEP_W-1:0] S_INS_WR = 5'd9;
	localparam logic [STEP_W-1:0] S_FIND_CHK = 5'd10;
	localparam logic [STEP_W-1:0] S_MISS_CHK = 5'd11;
	localparam logic [STEP_W-1:0] S_SWITCH = 5'd12;
	localparam logic [STEP_W-1:0] S_HIT = 5'd13;
	localparam logic [STEP_W-1:0] S_DN_RD = 5'd14;
	localparam logic [STEP_W-1:0] S_DN_WR = 5'd15;
	localparam logic [STEP_W-1:0] S_DN_END = 5'd16;
	localparam logic [STEP_W-1:0] S_E_DUP = 5'd17;
	localparam logic [STEP_W-1:0] S_E_FULL = 5'd18;
	localparam logic [STEP_W-1:0] S_E_OK = 5'd19;
	localparam logic [STEP_W-1:0] S_E_FOUND = 5'd20;
	localparam logic [STEP_W-1:0] S_E_NF = 5'd21;

	// microcode program: one control word per step
	function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
		ctrl_t w;
		w = '0;
		w.cond = C_NEVER;
		case (step)
			S_IDLE: begin
				w.act.init = 1'b1;
				w.cond = C_NO_REQ;
				w.target = S_IDLE;
			end
			S_PROBE: begin
				w.act.probe = 1'b1;
				w.cond = C_SEARCH_DONE;
				w.target = S_DISPATCH;
			end
			S_CMP: begin
				w.act.cmp = 1'b1;
				w.cond = C_ALWAYS;
				w.target = S_PROBE;
			end
			S_DISPATCH: begin
				w.cond = C_IS_FIND;
				w.target = S_FIND_CHK;
			end
			S_DUP_CHK: begin
				w.cond = C_FOUND;
				w.target = S_E_DUP;
			end
			S_FULL_CHK: begin
				w.cond = C_FULL;
				w.target = S_E_FULL;
			end
			S_UP_SET: begin
				w.act.up_set = 1'b1;
			end
			S_UP_RD: begin
				w.act.up_rd = 1'b1;
				w.cond = C_PTR_LE_LO;
				w.target = S_INS_WR;
			end
			S_UP_WR: begin
				w.act.up_wr = 1'b1;
				w.cond = C_ALWAYS;
				w.target = S_UP_RD;
			end
			S_INS_WR: begin
				w.act.ins_wr = 1'b1;
				w.cond = C_ALWAYS;
				w.target = S_E_OK;
			end
			S_FIND_CHK: begin
				w.cond = C_FOUND;
				w.target = S_HIT;
			end
			S_MISS_CHK: begin
				w.cond = C_BANK_ISO;
				w.target = S_E_NF;
			end
			S_SWITCH: begin
				w.act.next_bank = 1'b1;
				w.cond = C_ALWAYS;
				w.target = S_PROBE;
			end
			S_HIT: begin
				w.act.ptr_lo = 1'b1;
				w.cond = C_IS_LOOKUP;
				w.target = S_E_FOUND;
			end
			S_DN_RD: begin
				w.act.dn_rd = 1'b1;
				w.cond = C_PTR_AT_TOP;
				w.target = S_DN_END;
			end
			S_DN_WR: begin
				w.act.dn_wr = 1'b1;
				w.cond = C_ALWAYS;
				w.target = S_DN_RD;
			end
			S_DN_END: begin
				w.act.dec = 1'b1;
				w.cond = C_ALWAYS;
				w.target = S_E_FOUND;
			end
			S_E_DUP: begin
				w.act.emit = 1'b1;
				w.cond = C_OUT_BUSY;
				w.target = S_E_DUP;
				w.done = 1'b1;
				w.res.status = ST_DUP;
				w.res.pos_sel = 1'b1;
				w.res.bank_sel = 1'b1;
			end
			S_E_FULL: begin
				w.act.emit = 1'b1;
				w.cond = C_OUT_BUSY;
				w.target = S_E_FULL;
				w.done = 1'b1;
				w.res.status = ST_FULL;
				w.res.bank_sel = 1'b1;
			end
			S_E_OK: begin
				w.act.emit = 1'b1;
				w.cond = C_OUT_BUSY;
				w.target = S_E_OK;
				w.done = 1'b1;
				w.res.status = ST_OK;
				w.res.pos_sel = 1'b1;
				w.res.bank_sel = 1'b1;
			end
			S_E_FOUND: begin
				w.act.emit = 1'b1;
				w.cond = C_OUT_BUSY;
				w.target = S_E_FOUND;
				w.done = 1'b1;
				w.res.status = ST_OK;
				w.res.pos_sel = 1'b1;
				w.res.pay_sel = 1'b1;
				w.res.bank_sel = 1'b1;
			end
			S_E_NF: begin
				w.act.emit = 1'b1;
				w.cond = C_OUT_BUSY;
				w.target = S_E_NF;
				w.done = 1'b1;
				w.res.status = ST_NOT_FOUND;
			end
			default: begin
				w.done = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

/* src/skt_seq.sv */
`default_nettype none
module skt_seq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire skt_pkg::cond_t cond,
	output skt_pkg::ctrl_t     ctrl
);
	import skt_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic take;

	assign ctrl = ucode_rom(step_q);

	always_comb begin
		case (ctrl.cond)
			C_NEVER:       take = 1'b0;
			C_ALWAYS:      take = 1'b1;
			C_NO_REQ:      take = cond.no_req;
			C_SEARCH_DONE: take = cond.search_done;
			C_IS_FIND:     take = cond.is_find;
			C_FOUND:       take = cond.found;
			C_FULL:        take = cond.full;
			C_PTR_LE_LO:   take = cond.ptr_le_lo;
			C_BANK_ISO:    take = cond.bank_iso;
			C_IS_LOOKUP:   take = cond.is_lookup;
			C_PTR_AT_TOP:  take = cond.ptr_at_top;
			C_OUT_BUSY:    take = cond.out_busy;
			default:       take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else if (take) begin
			step_q <= ctrl.target;
		end else if (ctrl.done) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_q + STEP_W'(1);
		end
	end

endmodule
`default_nettype wire

/* src/skt_dp.sv */
`default_nettype none
module skt_dp #(
	parameter int BANK_DEPTH = skt_pkg::BANK_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire skt_pkg::ctrl_t    ctrl,
	input  wire logic              req_valid,
	input  wire skt_pkg::in_word_t req,
	input  wire logic              rsp_stall,
	output skt_pkg::cond_t         cond,
	output logic                   rsp_valid,
	output skt_pkg::out_word_t     rsp
);
	import skt_pkg::*;

	localparam int IDX_W = $clog2(BANK_DEPTH);
	localparam int CNT_W = $clog2(BANK_DEPTH + 1);
	localparam int ADDR_W = IDX_W + 1;
	localparam int MEM_DEPTH = 2 ** ADDR_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BANK_DEPTH);

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] pay;
	} entry_t;

	// both banks share one memory, bank selects the upper address bit
	entry_t mem [MEM_DEPTH];
	entry_t rdata_q;

	logic [1:0] op_q;
	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;
	logic bank_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi_q;
	logic [CNT_W-1:0] ptr_q;
	logic found_q;
	logic [PAY_W-1:0] hit_pay_q;
	logic [CNT_W-1:0] cnt_q [2];
	logic out_valid_q;
	out_word_t out_q;

	logic start;
	logic emit_en;
	logic bank_init;
	logic [CNT_W-1:0] cur_cnt;
	logic [CNT_W-1:0] mid;
	logic [CNT_W-1:0] rd_ptr;
	logic [CNT_W-1:0] wr_ptr;
	logic rd_en;
	logic wr_en;
	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] waddr;
	entry_t wdata;

	assign start = ctrl.act.init && req_valid;
	assign emit_en = ctrl.act.emit && !cond.out_busy;
	assign bank_init = (req.opcode == OP_STORE_ISO);
	assign cur_cnt = cnt_q[bank_q];
	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	always_comb begin
		if (ctrl.act.probe) begin
			rd_ptr = mid;
		end else if (ctrl.act.up_rd) begin
			rd_ptr = ptr_q - CNT_W'(1);
		end else begin
			rd_ptr = ptr_q + CNT_W'(1);
		end
	end

	assign rd_en = ctrl.act.probe || ctrl.act.up_rd || ctrl.act.dn_rd;
	assign wr_en = ctrl.act.up_wr || ctrl.act.dn_wr || ctrl.act.ins_wr;
	assign wr_ptr = ctrl.act.ins_wr ? lo_q : ptr_q;
	assign raddr = {bank_q, rd_ptr[IDX_W-1:0]};
	assign waddr = {bank_q, wr_ptr[IDX_W-1:0]};
	assign wdata = ctrl.act.ins_wr ? entry_t'{key: key_q, pay: pay_q} : rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	// command registers, search window, hit result and shift pointer
	always_ff @(posedge clk) begin
		if (start) begin
			op_q <= req.opcode;
			key_q <= req.key_id;
			pay_q <= req.payload_in;
			bank_q <= bank_init;
			lo_q <= '0;
			hi_q <= cnt_q[bank_init];
			found_q <= 1'b0;
		end
		if (ctrl.act.next_bank) begin
			bank_q <= 1'b1;
			lo_q <= '0;
			hi_q <= cnt_q[1];
			found_q <= 1'b0;
		end
		if (ctrl.act.cmp) begin
			if (rdata_q.key < key_q) begin
				lo_q <= mid + CNT_W'(1);
			end else begin
				// last probe on this side is the lower bound itself
				hi_q <= mid;
				found_q <= (rdata_q.key == key_q);
				hit_pay_q <= rdata_q.pay;
			end
		end
		if (ctrl.act.up_set) begin
			ptr_q <= cur_cnt;
		end
		if (ctrl.act.up_wr) begin
			ptr_q <= ptr_q - CNT_W'(1);
		end
		if (ctrl.act.ptr_lo) begin
			ptr_q <= lo_q;
		end
		if (ctrl.act.dn_wr) begin
			ptr_q <= ptr_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.act.ins_wr) begin
				cnt_q[bank_q] <= cur_cnt + CNT_W'(1);
			end
			if (ctrl.act.dec) begin
				cnt_q[bank_q] <= cur_cnt - CNT_W'(1);
			end
			if (emit_en) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			out_q.status <= ctrl.res.status;
			out_q.hit_bank <= ctrl.res.bank_sel ? bank_q : 1'b0;
			out_q.position <= ctrl.res.pos_sel ? POS_W'(lo_q) : '0;
			out_q.payload_out <= ctrl.res.pay_sel ? hit_pay_q : '0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	assign cond.no_req = !req_valid;
	assign cond.search_done = (lo_q >= hi_q);
	assign cond.is_find = (op_q == OP_RELEASE) || (op_q == OP_LOOKUP);
	assign cond.found = found_q;
	assign cond.full = (cur_cnt == FULL_CNT);
	assign cond.ptr_le_lo = (ptr_q <= lo_q);
	assign cond.bank_iso = bank_q;
	assign cond.is_lookup = (op_q == OP_LOOKUP);
	assign cond.ptr_at_top = ((ptr_q + CNT_W'(1)) >= cur_cnt);
	assign cond.out_busy = out_valid_q && rsp_stall;

endmodule
`default_nettype wire

/* src/sorted_key_table_two_banks.sv */
// Sorted key table with a normal and an isolated bank, BANK_DEPTH entries each.
// req channel: one word per command (store normal, store isolated, release,
// lookup). rsp channel: one word per command with status, bank, position and
// payload. Both channels are valid/stall; a word moves when valid is high and
// stall is low.
// One command is in flight at a time; req_stall is high from acceptance until
// the result has been loaded into the output register. A microcoded sequencer
// steps a datapath around a single-port memory; each binary-search probe is a
// probe step (address, then registered read data) and a compare step, p probes
// with p <= clog2(n+1) for a bank holding n entries.
// A lookup searches the normal bank and, on a miss, the isolated bank as well.
// A store searches its own bank, checks for a duplicate and a full bank, shifts
// larger entries up one place each and writes the new entry; a release is a
// lookup, then the later entries shift down and the bank's entry count drops.
// Reset clears both entry counts and the output valid; no clearing pass is run.
// A stalled result holds in the output register; the sequencer waits in its
// emit step while the receiver stalls and a finished result is still pending.
`default_nettype none
module sorted_key_table_two_banks #(
	parameter int BANK_DEPTH = skt_pkg::BANK_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire skt_pkg::in_word_t  req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output skt_pkg::out_word_t      rsp
);
	import skt_pkg::*;

	ctrl_t ctrl;
	cond_t cond;

	skt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.ctrl   (ctrl)
	);

	skt_dp #(
		.BANK_DEPTH (BANK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.req_valid (req_valid),
		.req       (req),
		.rsp_stall (rsp_stall),
		.cond      (cond),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	// only the idle step takes a command
	assign req_stall = !ctrl.act.init;

endmodule
`default_nettype wire

/* src/skt_checker.sv */
`default_nettype none
module skt_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               req_valid,
	input wire logic               req_stall,
	input wire logic               rsp_valid,
	input wire logic               rsp_stall,
	input wire skt_pkg::out_word_t rsp
);
	import skt_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result word changed or dropped");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second command taken while one is in flight");

	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_NOT_FOUND |->
			!rsp.hit_bank && rsp.position == '0 && rsp.payload_out == '0)
		else $error("miss result carries bank, position or payload");

	a_err_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.payload_out == '0)
		else $error("failed command returned a payload");

	a_full_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.position == '0)
		else $error("bank full result with nonzero position");

endmodule

bind sorted_key_table_two_banks skt_checker u_skt_checker (.*);
`default_nettype wire
